// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the pulse channel RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SQW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SQW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sqw_pkg.sv -----
// Types, codes and constants for the square wave sound channel.
// No dependencies.
package sqw_pkg;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_TIMER  = 3'd1;
  localparam logic [2:0] OP_LENGTH = 3'd2;
  localparam logic [2:0] OP_ENV    = 3'd3;
  localparam logic [2:0] OP_SWEEP  = 3'd4;

  localparam logic [2:0] REG_SWEEP = 3'd0;
  localparam logic [2:0] REG_DUTY  = 3'd1;
  localparam logic [2:0] REG_ENV   = 3'd2;
  localparam logic [2:0] REG_FLO   = 3'd3;
  localparam logic [2:0] REG_FHI   = 3'd4;

  localparam logic [6:0] LEN_FULL = 7'd64;

  localparam logic [7:0] DUTY_WAVE [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] reg_index;
    logic [7:0] write_byte;
  } sqw_item_t;

  typedef struct packed {
    logic [3:0] level;
    logic       channel_on;
  } sqw_result_t;

  // Next sweep frequency; bit 11 set means overflow past 2047.
  function automatic logic [11:0] sweep_calc(input logic [10:0] freq,
                                             input logic [2:0]  shift,
                                             input logic        falling);
    logic [11:0] delta;
    delta = {1'b0, freq >> shift};
    if (falling) begin
      sweep_calc = {1'b0, freq} - delta;
    end else begin
      sweep_calc = {1'b0, freq} + delta;
    end
  endfunction

endpackage

// ----- rtl/core/sqw_in_if.sv -----
// Request channel into the pulse channel: valid/ready plus item fields.
// No dependencies.
interface sqw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [2:0] reg_index;
  logic [7:0] write_byte;

  modport source (output valid, output op, output reg_index, output write_byte,
                  input ready);
  modport sink (input valid, input op, input reg_index, input write_byte,
                output ready);
endinterface

// ----- rtl/core/sqw_out_if.sv -----
// Result channel out of the pulse channel: valid/ready plus level and enable.
// No dependencies.
interface sqw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] level;
  logic       channel_on;

  modport source (output valid, output level, output channel_on, input ready);
  modport sink (input valid, input level, input channel_on, output ready);
endinterface

// ----- rtl/core/square_wave_sound_channel.sv -----
// Pulse sound channel: length counter, volume envelope, optional frequency sweep.
// A request is held in the input register; its result is then registered in the output register.
// Throughput: one request per cycle while the sink takes results; input and output registers decouple the sides.
// Reset (synchronous, rst_n low): all channel state cleared, sweep unit present.
// Depends on sqw_pkg, sqw_in_if, sqw_out_if, sqw_in_stage, sqw_core, sqw_out_stage.
module square_wave_sound_channel (
  input  logic       clk,
  input  logic       rst_n,
  sqw_in_if.sink     in_if,
  sqw_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  sqw_pkg::sqw_item_t   in_item;
  sqw_pkg::sqw_item_t   item;
  sqw_pkg::sqw_result_t result;
  sqw_pkg::sqw_result_t out_result;
  logic                 in_ready;
  logic                 item_valid;
  logic                 step;
  logic                 out_valid;

  assign in_item.op         = in_if.op;
  assign in_item.reg_index  = in_if.reg_index;
  assign in_item.write_byte = in_if.write_byte;
  assign in_if.ready        = in_ready;

  assign out_if.valid       = out_valid;
  assign out_if.level       = out_result.level;
  assign out_if.channel_on  = out_result.channel_on;

  sqw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .step       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  sqw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  sqw_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .step       (step),
    .out_valid  (out_valid),
    .out_ready  (out_if.ready),
    .out_result (out_result)
  );

endmodule

// ----- rtl/core/sqw_in_stage.sv -----
// Input register for pulse channel requests.
// Depends on sqw_pkg.
module sqw_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sqw_pkg::sqw_item_t   in_item,
  input  logic                 step,
  output logic                 item_valid,
  output sqw_pkg::sqw_item_t   item
);

  logic               valid_r;
  logic               valid_nxt;
  sqw_pkg::sqw_item_t item_r;

  assign in_ready   = !valid_r || step;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/core/sqw_core.sv -----
// Channel state and per-request update: register writes, timer, length, envelope, sweep.
// Depends on sqw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sqw_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  step,
  input  sqw_pkg::sqw_item_t    item,
  output sqw_pkg::sqw_result_t  result
);

  logic        sweep_present_r;
  logic [10:0] tone_r, tone_nxt;
  logic [10:0] pcount_r, pcount_nxt;
  logic [2:0]  dstep_r, dstep_nxt;
  logic [1:0]  dsel_r, dsel_nxt;
  logic [6:0]  len_r, len_nxt;
  logic        len_on_r, len_on_nxt;
  logic        en_r, en_nxt;
  logic        dac_r, dac_nxt;
  logic [3:0]  vol_r, vol_nxt;
  logic [3:0]  env_reload_r, env_reload_nxt;
  logic        env_rising_r, env_rising_nxt;
  logic [2:0]  env_period_r, env_period_nxt;
  logic [2:0]  env_count_r, env_count_nxt;
  logic        env_active_r, env_active_nxt;
  logic [2:0]  sw_shift_r, sw_shift_nxt;
  logic        sw_falling_r, sw_falling_nxt;
  logic [2:0]  sw_period_r, sw_period_nxt;
  logic [2:0]  sw_count_r, sw_count_nxt;
  logic        sw_active_r, sw_active_nxt;
  logic [10:0] shadow_r, shadow_nxt;

  logic [7:0]  d;
  logic [10:0] tone_hi;
  logic [11:0] trig_calc;
  logic [11:0] sw_new;
  logic [11:0] sw_recheck;
  logic        wave_bit;

  assign d          = item.write_byte;
  assign tone_hi    = {d[2:0], tone_r[7:0]};
  assign trig_calc  = sqw_pkg::sweep_calc(tone_hi, sw_shift_r, sw_falling_r);
  assign sw_new     = sqw_pkg::sweep_calc(shadow_r, sw_shift_r, sw_falling_r);
  assign sw_recheck = sqw_pkg::sweep_calc(sw_new[10:0], sw_shift_r, sw_falling_r);

  always_comb begin
    tone_nxt       = tone_r;
    pcount_nxt     = pcount_r;
    dstep_nxt      = dstep_r;
    dsel_nxt       = dsel_r;
    len_nxt        = len_r;
    len_on_nxt     = len_on_r;
    en_nxt         = en_r;
    dac_nxt        = dac_r;
    vol_nxt        = vol_r;
    env_reload_nxt = env_reload_r;
    env_rising_nxt = env_rising_r;
    env_period_nxt = env_period_r;
    env_count_nxt  = env_count_r;
    env_active_nxt = env_active_r;
    sw_shift_nxt   = sw_shift_r;
    sw_falling_nxt = sw_falling_r;
    sw_period_nxt  = sw_period_r;
    sw_count_nxt   = sw_count_r;
    sw_active_nxt  = sw_active_r;
    shadow_nxt     = shadow_r;
    case (item.op)
      sqw_pkg::OP_WRITE: begin
        case (item.reg_index)
          sqw_pkg::REG_SWEEP: begin
            sw_shift_nxt   = d[2:0];
            sw_falling_nxt = d[3];
            sw_period_nxt  = d[6:4];
          end
          sqw_pkg::REG_DUTY: begin
            dsel_nxt = d[7:6];
            len_nxt  = sqw_pkg::LEN_FULL - {1'b0, d[5:0]};
          end
          sqw_pkg::REG_ENV: begin
            env_reload_nxt = d[7:4];
            env_rising_nxt = d[3];
            env_period_nxt = d[2:0];
            if (d[7:3] == 5'd0) begin
              dac_nxt = 1'b0;
              en_nxt  = 1'b0;
            end else begin
              dac_nxt = 1'b1;
            end
          end
          sqw_pkg::REG_FLO: begin
            tone_nxt = {tone_r[10:8], d};
          end
          sqw_pkg::REG_FHI: begin
            tone_nxt   = tone_hi;
            len_on_nxt = d[6];
            if (d[7]) begin
              en_nxt = dac_r;
              if (len_r == 7'd0) begin
                len_nxt = sqw_pkg::LEN_FULL;
              end
              pcount_nxt     = ~tone_hi;
              env_active_nxt = 1'b1;
              env_count_nxt  = env_period_r;
              vol_nxt        = env_reload_r;
              if (sweep_present_r) begin
                shadow_nxt    = tone_hi;
                sw_count_nxt  = sw_period_r;
                sw_active_nxt = (sw_period_r != 3'd0) || (sw_shift_r != 3'd0);
                if ((sw_shift_r != 3'd0) && trig_calc[11]) begin
                  en_nxt = 1'b0;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      sqw_pkg::OP_TIMER: begin
        if (pcount_r == 11'd0) begin
          pcount_nxt = ~tone_r;
          dstep_nxt  = dstep_r + 3'd1;
        end else begin
          pcount_nxt = pcount_r - 11'd1;
        end
      end
      sqw_pkg::OP_LENGTH: begin
        if (len_on_r && (len_r != 7'd0)) begin
          len_nxt = len_r - 7'd1;
          if (len_r == 7'd1) begin
            en_nxt = 1'b0;
          end
        end
      end
      sqw_pkg::OP_ENV: begin
        if (env_active_r && (env_period_r != 3'd0)) begin
          if (env_count_r > 3'd1) begin
            env_count_nxt = env_count_r - 3'd1;
          end else begin
            env_count_nxt = env_period_r;
            if (env_rising_r && (vol_r != 4'd15)) begin
              vol_nxt = vol_r + 4'd1;
            end else if (!env_rising_r && (vol_r != 4'd0)) begin
              vol_nxt = vol_r - 4'd1;
            end else begin
              env_active_nxt = 1'b0;
            end
          end
        end
      end
      sqw_pkg::OP_SWEEP: begin
        if (sweep_present_r && sw_active_r && (sw_period_r != 3'd0)) begin
          if (sw_count_r > 3'd1) begin
            sw_count_nxt = sw_count_r - 3'd1;
          end else begin
            sw_count_nxt = sw_period_r;
            if (sw_new[11]) begin
              en_nxt = 1'b0;
            end else if (sw_shift_r != 3'd0) begin
              shadow_nxt = sw_new[10:0];
              tone_nxt   = sw_new[10:0];
              if (sw_recheck[11]) begin
                en_nxt = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign wave_bit          = sqw_pkg::DUTY_WAVE[dsel_nxt][~dstep_nxt];
  assign result.level      = (en_nxt && dac_nxt && wave_bit) ? vol_nxt : 4'd0;
  assign result.channel_on = en_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_present_r <= 1'b1;
    end else if (cfg_we) begin
      sweep_present_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r       <= '0;
      pcount_r     <= '0;
      dstep_r      <= '0;
      dsel_r       <= '0;
      len_r        <= '0;
      len_on_r     <= 1'b0;
      en_r         <= 1'b0;
      dac_r        <= 1'b0;
      vol_r        <= '0;
      env_reload_r <= '0;
      env_rising_r <= 1'b0;
      env_period_r <= '0;
      env_count_r  <= '0;
      env_active_r <= 1'b0;
      sw_shift_r   <= '0;
      sw_falling_r <= 1'b0;
      sw_period_r  <= '0;
      sw_count_r   <= '0;
      sw_active_r  <= 1'b0;
      shadow_r     <= '0;
    end else if (step) begin
      tone_r       <= tone_nxt;
      pcount_r     <= pcount_nxt;
      dstep_r      <= dstep_nxt;
      dsel_r       <= dsel_nxt;
      len_r        <= len_nxt;
      len_on_r     <= len_on_nxt;
      en_r         <= en_nxt;
      dac_r        <= dac_nxt;
      vol_r        <= vol_nxt;
      env_reload_r <= env_reload_nxt;
      env_rising_r <= env_rising_nxt;
      env_period_r <= env_period_nxt;
      env_count_r  <= env_count_nxt;
      env_active_r <= env_active_nxt;
      sw_shift_r   <= sw_shift_nxt;
      sw_falling_r <= sw_falling_nxt;
      sw_period_r  <= sw_period_nxt;
      sw_count_r   <= sw_count_nxt;
      sw_active_r  <= sw_active_nxt;
      shadow_r     <= shadow_nxt;
    end
  end

  // Channel can only be enabled while the DAC is powered.
  `SQW_ASSERT_IMP(a_en_needs_dac, en_r, dac_r, "channel enabled with DAC off")
  // Length expiring on the last count turns the channel off.
  `SQW_ASSERT_NXT(a_len_expire,
    step && (item.op == sqw_pkg::OP_LENGTH) && len_on_r && (len_r == 7'd1),
    !en_r && (len_r == 7'd0), "length expiry did not disable channel")

endmodule

// ----- rtl/core/sqw_out_stage.sv -----
// Output register holding one result until the sink takes it.
// Depends on sqw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sqw_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  sqw_pkg::sqw_result_t  result,
  output logic                  step,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sqw_pkg::sqw_result_t  out_result
);

  logic                 valid_r;
  logic                 valid_nxt;
  sqw_pkg::sqw_result_t result_r;

  assign step       = item_valid && (!valid_r || out_ready);
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  // A nonzero level is only produced by an enabled channel.
  `SQW_ASSERT_IMP(a_level_needs_on, valid_r && (result_r.level != 4'd0),
    result_r.channel_on, "nonzero level with channel off")

endmodule
